/* rtl/mrpt_pkg.sv */
// Shared types and constants for the memory reserve phase tracker.
// Used by the datapath, the controller and the top level; depends on nothing.
`default_nettype none

package mrpt_pkg;

  // Default widths of the sample and the sample counter.
  localparam int SAMPLE_BITS_DEF = 20;
  localparam int COUNT_BITS_DEF  = 20;

  // Fixed field widths.
  localparam int RESERVE_W = 24;
  localparam int BAND_W    = 20;
  localparam int GUARD_W   = 4;
  localparam int RUNLEN_W  = 8;
  localparam int WARMUP_W  = 20;
  localparam int EV_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam logic [RESERVE_W-1:0] RESERVE_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_STEPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SAMPLES = 2'd3;

  // Reset values of the registers.
  localparam logic [BAND_W-1:0]   LIMIT_RST  = 20'd1048575;
  localparam logic [GUARD_W-1:0]  GUARD_RST  = 4'd2;
  localparam logic [RUNLEN_W-1:0] RUNLEN_RST = 8'd5;
  localparam logic [WARMUP_W-1:0] WARMUP_RST = 20'd10;

  // Phase event and run direction codes.
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_UP   = 2'd1;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd2;

  // Divider operand selection.
  localparam logic [1:0] DIV_TSUM = 2'd0;
  localparam logic [1:0] DIV_TSQ  = 2'd1;
  localparam logic [1:0] DIV_RSUM = 2'd2;
  localparam logic [1:0] DIV_RSQ  = 2'd3;

  typedef struct packed {
    logic [BAND_W-1:0]   reserve_limit;
    logic [GUARD_W-1:0]  guard_steps;
    logic [RUNLEN_W-1:0] run_length;
    logic [WARMUP_W-1:0] warmup_samples;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       div_go;
    logic [1:0] div_sel;
    logic       sqrt_go;
    logic       upd;
    logic       band;
    logic       run_fin;
    logic       emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_stats;
    logic warm;
    logic div_done;
    logic sqrt_done;
    logic run_hit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/mrpt_div.sv */
// Restoring divider, one quotient bit per cycle.
// Used by the datapath; depends on nothing.
`default_nettype none

module mrpt_div #(
  parameter int DVD_W = 60,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] sh_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0] rem_sh;
  logic           ge;
  logic [DVS_W:0] rem_new;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_r, sh_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_new = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (go) begin
      sh_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= {sh_r[DVD_W-2:0], ge};
      rem_r <= rem_new[DVS_W-1:0];
    end
  end

  assign quo  = sh_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/mrpt_sqrt.sv */
// Digit-by-digit floor square root, one root bit per cycle.
// Used by the datapath; depends on nothing.
`default_nettype none

module mrpt_sqrt #(
  parameter int ROOT_W = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [2*ROOT_W-1:0] op,
  output logic [ROOT_W-1:0]   root,
  output logic                done
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] sh_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;
  logic [REM_W+1:0] rem_new;

  // Bring down two bits and try root*4+1.
  always_comb begin
    rem_sh  = {rem_r, sh_r[2*ROOT_W-1:2*ROOT_W-2]};
    trial   = (REM_W+2)'({root_r, 2'b01});
    ge      = rem_sh >= trial;
    rem_new = ge ? rem_sh - trial : rem_sh;
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand, remainder and root registers.
  always_ff @(posedge clk) begin
    if (go) begin
      sh_r   <= op;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      sh_r   <= {sh_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= rem_new[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/mrpt_dp.sv */
// Datapath: totals, statistics, bands, run tracking and the result register.
// Depends on mrpt_pkg, mrpt_div and mrpt_sqrt.
`default_nettype none

module mrpt_dp #(
  parameter int SAMPLE_BITS = 20,
  parameter int COUNT_BITS  = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mrpt_pkg::cfg_t                       cfg,
  input  mrpt_pkg::cmd_t                       cmd,
  output mrpt_pkg::sts_t                       sts,
  input  logic [SAMPLE_BITS-1:0]               sample,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [mrpt_pkg::RESERVE_W-1:0]       reserve_mib,
  output logic [mrpt_pkg::BAND_W-1:0]          upper_band,
  output logic [mrpt_pkg::BAND_W-1:0]          lower_band,
  output logic [mrpt_pkg::EV_W-1:0]            phase_event,
  output logic                                 warming
);

  import mrpt_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int C      = COUNT_BITS;
  localparam int TSUM_W = S + C;
  localparam int TSQ_W  = (2 * S + C > 64) ? 64 : 2 * S + C;
  localparam int SQ_W   = 2 * S;
  localparam int RSUM_W = S + RUNLEN_W;
  localparam int RSQ_W  = 2 * S + RUNLEN_W;
  localparam int GD_W   = S + GUARD_W;
  localparam int BW     = (S + GUARD_W + 1 > RESERVE_W) ? S + GUARD_W + 1 : RESERVE_W;
  localparam int CMPW   = (C > WARMUP_W) ? C : WARMUP_W;
  localparam logic [C-1:0] CMAX = '1;
  localparam logic [BAND_W-1:0] BAND_MASK =
    (S >= BAND_W) ? '1 : BAND_W'((1 << S) - 1);

  // Item and statistics registers.
  logic [S-1:0]        x_r;
  logic [SQ_W-1:0]     xx_r;
  logic                warm_r;
  logic [TSUM_W-1:0]   tsum_r;
  logic [TSQ_W-1:0]    tsq_r;
  logic [C-1:0]        cnt_r;
  logic [RESERVE_W-1:0] reserve_r;
  logic [EV_W-1:0]     run_dir_r;
  logic [RUNLEN_W-1:0] run_len_r;
  logic [RSUM_W-1:0]   run_sum_r;
  logic [RSQ_W-1:0]    run_sq_r;
  logic [S-1:0]        run_peak_r;
  logic [S-1:0]        mean_r;
  logic [SQ_W-1:0]     msq_r;
  logic [SQ_W-1:0]     varq_r;
  logic [S-1:0]        dev_r;
  logic [GD_W-1:0]     gd_r;
  logic [BAND_W-1:0]   up_r;
  logic [BAND_W-1:0]   lo_r;
  logic [EV_W-1:0]     dir_r;
  logic [EV_W-1:0]     ev_r;
  logic [1:0]          div_sel_r;

  // Result register.
  logic                 out_valid_r;
  logic [RESERVE_W-1:0] out_res_r;
  logic [BAND_W-1:0]    out_up_r;
  logic [BAND_W-1:0]    out_lo_r;
  logic [EV_W-1:0]      out_ev_r;
  logic                 out_warm_r;

  logic               warm_now;
  logic [TSQ_W-1:0]   div_dvd;
  logic [C-1:0]       div_dvs;
  logic [TSQ_W-1:0]   div_quo;
  logic               div_done;
  logic [SQ_W-1:0]    var_diff;
  logic [S-1:0]       sq_root;
  logic               sq_done;

  logic [TSUM_W:0]    tsum_add;
  logic [TSQ_W:0]     tsq_add;

  logic [BW-1:0]       x_b, mean_b, gd_b, up_raw, up_cap, lim_b, lo_b;
  logic [BW-1:0]       res_add, fin_add;
  logic [GD_W-1:0]     run_gd;
  logic [EV_W-1:0]     dir;
  logic                same_dir;
  logic [RUNLEN_W-1:0] new_len;
  logic [RSUM_W-1:0]   new_sum;
  logic [RSQ_W-1:0]    new_sq;
  logic [S-1:0]        new_peak;
  logic                run_hit;

  // Warm-up test against the count held before this sample.
  assign warm_now = CMPW'(cnt_r) < CMPW'(cfg.warmup_samples);

  // Shared divider: operands chosen by the controller.
  always_comb begin
    unique case (cmd.div_sel)
      DIV_TSUM: div_dvd = TSQ_W'(tsum_r);
      DIV_TSQ:  div_dvd = tsq_r;
      DIV_RSUM: div_dvd = TSQ_W'(run_sum_r);
      DIV_RSQ:  div_dvd = TSQ_W'(run_sq_r);
      default:  div_dvd = '0;
    endcase
    div_dvs = (cmd.div_sel == DIV_TSUM || cmd.div_sel == DIV_TSQ) ?
              cnt_r : C'(run_len_r);
  end

  mrpt_div #(.DVD_W(TSQ_W), .DVS_W(C)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (div_quo),
    .done     (div_done)
  );

  // Variance with negative values clamped to zero.
  assign var_diff = (varq_r > msq_r) ? varq_r - msq_r : '0;

  mrpt_sqrt #(.ROOT_W(S)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.sqrt_go),
    .op    (var_diff),
    .root  (sq_root),
    .done  (sq_done)
  );

  // Saturating total updates.
  assign tsum_add = (TSUM_W+1)'(tsum_r) + (TSUM_W+1)'(x_r);
  assign tsq_add  = (TSQ_W+1)'(tsq_r) + (TSQ_W+1)'(xx_r);

  // Bands, direction and the next run values.
  always_comb begin
    x_b      = BW'(x_r);
    mean_b   = BW'(mean_r);
    gd_b     = BW'(gd_r);
    lim_b    = BW'(cfg.reserve_limit);
    up_raw   = mean_b + gd_b;
    up_cap   = (up_raw > lim_b) ? lim_b : up_raw;
    lo_b     = (mean_b > gd_b) ? mean_b - gd_b : '0;
    if (x_b > up_cap) begin
      dir = EV_UP;
    end else if (x_b < lo_b) begin
      dir = EV_DOWN;
    end else begin
      dir = EV_NONE;
    end
    same_dir = run_dir_r == dir;
    new_len  = (same_dir ? run_len_r : '0) + 1'b1;
    new_sum  = (same_dir ? run_sum_r : '0) + RSUM_W'(x_r);
    new_sq   = (same_dir ? run_sq_r : '0) + RSQ_W'(xx_r);
    new_peak = (same_dir && run_peak_r > x_r) ? run_peak_r : x_r;
    run_hit  = (dir != EV_NONE) && (new_len >= cfg.run_length);
    res_add  = x_b + gd_b;
    run_gd   = GD_W'(cfg.guard_steps) * GD_W'(dev_r);
    fin_add  = BW'(run_peak_r) + BW'(run_gd);
  end

  // Statistics and run state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsum_r     <= '0;
      tsq_r      <= '0;
      cnt_r      <= '0;
      reserve_r  <= RESERVE_W'(LIMIT_RST);
      run_dir_r  <= EV_NONE;
      run_len_r  <= '0;
      run_sum_r  <= '0;
      run_sq_r   <= '0;
      run_peak_r <= '0;
    end else begin
      if (cmd.upd && cnt_r != CMAX) begin
        tsum_r <= tsum_add[TSUM_W] ? '1 : tsum_add[TSUM_W-1:0];
        tsq_r  <= tsq_add[TSQ_W] ? '1 : tsq_add[TSQ_W-1:0];
        cnt_r  <= cnt_r + 1'b1;
      end
      if (cmd.band) begin
        if (x_b >= BW'(reserve_r)) begin
          reserve_r <= (res_add > BW'(RESERVE_MAX)) ? RESERVE_MAX : res_add[RESERVE_W-1:0];
        end
        if (dir == EV_NONE) begin
          run_dir_r  <= EV_NONE;
          run_len_r  <= '0;
          run_sum_r  <= '0;
          run_sq_r   <= '0;
          run_peak_r <= '0;
        end else begin
          run_dir_r  <= dir;
          run_len_r  <= new_len;
          run_sum_r  <= new_sum;
          run_sq_r   <= new_sq;
          run_peak_r <= new_peak;
        end
      end else if (cmd.run_fin) begin
        reserve_r  <= (fin_add > BW'(RESERVE_MAX)) ? RESERVE_MAX : fin_add[RESERVE_W-1:0];
        run_dir_r  <= EV_NONE;
        run_len_r  <= '0;
        run_sum_r  <= '0;
        run_sq_r   <= '0;
        run_peak_r <= '0;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    msq_r <= mean_r * mean_r;
    if (cmd.take) begin
      x_r    <= sample;
      xx_r   <= SQ_W'(sample) * SQ_W'(sample);
      warm_r <= warm_now;
      mean_r <= '0;
      dev_r  <= '0;
      up_r   <= '0;
      lo_r   <= '0;
      ev_r   <= EV_NONE;
    end else begin
      if (div_done) begin
        if (div_sel_r == DIV_TSUM || div_sel_r == DIV_RSUM) begin
          mean_r <= div_quo[S-1:0];
        end else begin
          varq_r <= div_quo[SQ_W-1:0];
        end
      end
      if (sq_done) begin
        dev_r <= sq_root;
      end
      if (cmd.upd) begin
        gd_r <= GD_W'(cfg.guard_steps) * GD_W'(dev_r);
      end
      if (cmd.band) begin
        up_r  <= up_cap[BAND_W-1:0] & BAND_MASK;
        lo_r  <= lo_b[BAND_W-1:0] & BAND_MASK;
        dir_r <= dir;
      end
      if (cmd.run_fin) begin
        ev_r <= dir_r;
      end
    end
    if (cmd.div_go) begin
      div_sel_r <= cmd.div_sel;
    end
  end

  // Result register: a finished result waits here for the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_res_r  <= reserve_r;
      out_up_r   <= up_r;
      out_lo_r   <= lo_r;
      out_ev_r   <= ev_r;
      out_warm_r <= warm_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.need_stats = !warm_now && cnt_r != '0;
    sts.warm       = warm_r;
    sts.div_done   = div_done;
    sts.sqrt_done  = sq_done;
    sts.run_hit    = run_hit;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign reserve_mib = out_res_r;
  assign upper_band  = out_up_r;
  assign lower_band  = out_lo_r;
  assign phase_event = out_ev_r;
  assign warming     = out_warm_r;

endmodule

`default_nettype wire

/* rtl/mrpt_ctrl.sv */
// Controller state machine sequencing one sample through the datapath.
// Depends on mrpt_pkg.
`default_nettype none

module mrpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrpt_pkg::sts_t sts,
  output mrpt_pkg::cmd_t cmd
);

  import mrpt_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_W_MEAN   = 4'd1;
  localparam logic [3:0] ST_W_VARQ   = 4'd2;
  localparam logic [3:0] ST_SQRT_GO  = 4'd3;
  localparam logic [3:0] ST_W_DEV    = 4'd4;
  localparam logic [3:0] ST_UPD      = 4'd5;
  localparam logic [3:0] ST_BAND     = 4'd6;
  localparam logic [3:0] ST_RUN_GO   = 4'd7;
  localparam logic [3:0] ST_W_RMEAN  = 4'd8;
  localparam logic [3:0] ST_W_RVARQ  = 4'd9;
  localparam logic [3:0] ST_RSQRT_GO = 4'd10;
  localparam logic [3:0] ST_W_RDEV   = 4'd11;
  localparam logic [3:0] ST_RFIN     = 4'd12;
  localparam logic [3:0] ST_DONE     = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = state_r == ST_IDLE;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.need_stats) begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_TSUM;
            state_nxt   = ST_W_MEAN;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_W_MEAN: begin
        if (sts.div_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_TSQ;
          state_nxt   = ST_W_VARQ;
        end
      end
      ST_W_VARQ: begin
        if (sts.div_done) begin
          state_nxt = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = ST_W_DEV;
      end
      ST_W_DEV: begin
        if (sts.sqrt_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.warm ? ST_DONE : ST_BAND;
      end
      ST_BAND: begin
        cmd.band  = 1'b1;
        state_nxt = sts.run_hit ? ST_RUN_GO : ST_DONE;
      end
      ST_RUN_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_RSUM;
        state_nxt   = ST_W_RMEAN;
      end
      ST_W_RMEAN: begin
        if (sts.div_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_RSQ;
          state_nxt   = ST_W_RVARQ;
        end
      end
      ST_W_RVARQ: begin
        if (sts.div_done) begin
          state_nxt = ST_RSQRT_GO;
        end
      end
      ST_RSQRT_GO: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = ST_W_RDEV;
      end
      ST_W_RDEV: begin
        if (sts.sqrt_done) begin
          state_nxt = ST_RFIN;
        end
      end
      ST_RFIN: begin
        cmd.run_fin = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/memory_reserve_phase_tracker_core.sv */
// Top level of the memory reserve phase tracker: configuration registers,
// controller and datapath. Depends on mrpt_pkg, mrpt_ctrl and mrpt_dp.
`default_nettype none

// One memory-use sample enters per in_ beat and yields exactly one result beat.
// Warm-up samples and a sample after warm-up with empty totals skip the
// statistics. Any other sample after warm-up runs the mean and mean-square
// divisions on the shared bit-serial divider, TSQ bits wide, where TSQ is
// min(2*SAMPLE_BITS + COUNT_BITS, 64), one bit per cycle, and the square root
// unit produces one root bit per cycle. A sample that completes a run adds a
// second pass of the same units.
// One sample is in work at a time; the next is taken while the previous
// result still waits in the output register. The user must write
// configuration only while the block is idle; the block itself does not
// enforce it. cfg_ready is always high.
module memory_reserve_phase_tracker_core #(
  parameter int SAMPLE_BITS = mrpt_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = mrpt_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample_mib, zero padded to whole bytes
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // reserve_mib [23:0], upper_band [43:24], lower_band [63:44]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [63:0]                          out_tdata,
  // phase_event [1:0], warming [2]
  output logic [2:0]                           out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mrpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrpt_pkg::CFG_DAT_W-1:0]       cfg_data
);

  import mrpt_pkg::*;

  logic [BAND_W-1:0]   limit_r;
  logic [GUARD_W-1:0]  guard_r;
  logic [RUNLEN_W-1:0] runlen_r;
  logic [WARMUP_W-1:0] warmup_r;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic [RESERVE_W-1:0] reserve_mib;
  logic [BAND_W-1:0]    upper_band;
  logic [BAND_W-1:0]    lower_band;
  logic [EV_W-1:0]      phase_event;
  logic                 warming;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      guard_r  <= GUARD_RST;
      runlen_r <= RUNLEN_RST;
      warmup_r <= WARMUP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESERVE_LIMIT:  limit_r  <= cfg_data[BAND_W-1:0];
        CFG_GUARD_STEPS:    guard_r  <= cfg_data[GUARD_W-1:0];
        CFG_RUN_LENGTH:     runlen_r <= cfg_data[RUNLEN_W-1:0];
        CFG_WARMUP_SAMPLES: warmup_r <= cfg_data[WARMUP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.reserve_limit  = limit_r;
    cfg.guard_steps    = guard_r;
    cfg.run_length     = runlen_r;
    cfg.warmup_samples = warmup_r;
  end

  mrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrpt_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .reserve_mib (reserve_mib),
    .upper_band  (upper_band),
    .lower_band  (lower_band),
    .phase_event (phase_event),
    .warming     (warming)
  );

  // Result beat packing.
  assign out_tdata = {lower_band, upper_band, reserve_mib};
  assign out_tuser = {warming, phase_event};

endmodule

`default_nettype wire
